>>> rtl/hcti_pkg.sv
// Shared constants, types and the specific heat table for the interpolator.
`default_nettype none

package hcti_pkg;

  localparam int TEMP_W         = 16;
  localparam int CAP_W          = 18;
  localparam int TABLE_POINTS   = 29;
  localparam int TEMP_FRAC_BITS = 4;
  localparam int STORED_POINTS  = 29;
  localparam int USED_POINTS    = (TABLE_POINTS > STORED_POINTS) ? STORED_POINTS :
                                  ((TABLE_POINTS < 1) ? 1 : TABLE_POINTS);

  localparam longint KELVIN_FIRST = 300;
  localparam longint KELVIN_STEP  = 100;
  localparam longint STEP         = KELVIN_STEP << TEMP_FRAC_BITS;
  localparam longint BASE         = KELVIN_FIRST << TEMP_FRAC_BITS;
  localparam longint TOP          = BASE + (USED_POINTS - 1) * STEP;

  localparam int SEG_W = $clog2(STORED_POINTS);
  localparam int REM_W = $clog2(STEP);

  // Segment index: multiply by a rounded-up reciprocal of the step, exact for 16-bit offsets
  localparam int     DIV1_SHIFT = TEMP_W + $clog2(STEP);
  localparam int     M1_W       = TEMP_W + 1;
  localparam int     QP_W       = TEMP_W + M1_W;
  localparam logic [M1_W-1:0] DIV1_MULT =
    M1_W'(((64'd1 << DIV1_SHIFT) + STEP - 1) / STEP);

  // Blend: (diff * rem + step/2) / step, done as a shift by the fraction bits
  // followed by a reciprocal multiply for the division by the kelvin step
  localparam int PROD_W = CAP_W + REM_W;
  localparam int SH_W   = PROD_W + 1 - TEMP_FRAC_BITS;
  localparam logic [PROD_W:0] HALF = (PROD_W + 1)'(STEP >> 1);
  localparam int DIV2_SHIFT = SH_W + $clog2(KELVIN_STEP);
  localparam int M2_W       = SH_W + 1;
  localparam int P2_W       = SH_W + M2_W;
  localparam logic [M2_W-1:0] DIV2_MULT =
    M2_W'(((64'd1 << DIV2_SHIFT) + KELVIN_STEP - 1) / KELVIN_STEP);

  localparam logic [CAP_W-1:0] CP_TABLE [STORED_POINTS] = '{
    18'd60291,  18'd68042,  18'd72228,  18'd74806,  18'd76572,  18'd77885,
    18'd78930,  18'd79805,  18'd80579,  18'd81303,  18'd82033,  18'd82842,
    18'd83817,  18'd85071,  18'd86725,  18'd88909,  18'd91750,  18'd95370,
    18'd99871,  18'd105334, 18'd111816, 18'd119350, 18'd127949, 18'd137600,
    18'd148268, 18'd159905, 18'd172449, 18'd185825, 18'd199956
  };

  localparam logic [CAP_W-1:0] CP_FIRST = CP_TABLE[0];
  localparam logic [CAP_W-1:0] CP_LAST  = CP_TABLE[USED_POINTS-1];

  // Segment word handed from the lookup stages to the blend stages
  typedef struct packed {
    logic             valid;
    logic [CAP_W-1:0] lo;
    logic [CAP_W-1:0] diff;
    logic [REM_W-1:0] rem;
  } seg_t;

  function automatic logic [CAP_W-1:0] cp_lookup(input logic [SEG_W-1:0] idx);
    logic [CAP_W-1:0] v;
    v = '0;
    if (int'(idx) < STORED_POINTS) v = CP_TABLE[idx];
    return v;
  endfunction

endpackage

`default_nettype wire

>>> rtl/hcti_segment.sv
// Clamp detection, segment index by reciprocal multiply and table lookup (three stages).
`default_nettype none

module hcti_segment (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  input  wire logic [hcti_pkg::TEMP_W-1:0] temperature,
  output hcti_pkg::seg_t             seg_out
);
  import hcti_pkg::*;

  logic              valid1, below1, above1;
  logic [TEMP_W-1:0] off1;
  logic              valid2, below2, above2;
  logic [TEMP_W-1:0] off2;
  logic [QP_W-1:0]   qprod2;
  seg_t              seg;

  logic [SEG_W-1:0]  idx;
  logic [TEMP_W-1:0] rem_full;
  logic [CAP_W-1:0]  lo_v, hi_v;
  seg_t              seg_next;

  always_comb begin
    idx      = qprod2[DIV1_SHIFT +: SEG_W];
    rem_full = off2 - TEMP_W'(longint'(idx) * STEP);
    lo_v     = cp_lookup(idx);
    hi_v     = cp_lookup(idx + SEG_W'(1));
    seg_next.valid = valid2;
    seg_next.rem   = rem_full[REM_W-1:0];
    if (below2) begin
      seg_next.lo   = CP_FIRST;
      seg_next.diff = '0;
    end else if (above2) begin
      seg_next.lo   = CP_LAST;
      seg_next.diff = '0;
    end else begin
      seg_next.lo   = lo_v;
      seg_next.diff = (hi_v > lo_v) ? (hi_v - lo_v) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1    <= 1'b0;
      valid2    <= 1'b0;
      seg.valid <= 1'b0;
    end else begin
      valid1    <= in_valid;
      valid2    <= valid1;
      seg.valid <= seg_next.valid;
    end
    below1 <= longint'(temperature) <= BASE;
    above1 <= longint'(temperature) >= TOP;
    off1   <= temperature - TEMP_W'(BASE);
    below2 <= below1;
    above2 <= above1;
    off2   <= off1;
    qprod2 <= off1 * DIV1_MULT;
    seg.lo   <= seg_next.lo;
    seg.diff <= seg_next.diff;
    seg.rem  <= seg_next.rem;
  end

  assign seg_out = seg;

endmodule

`default_nettype wire

>>> rtl/hcti_blend.sv
// Interpolation between the segment ends with round-half-up division by the step (three stages).
`default_nettype none

module hcti_blend (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire hcti_pkg::seg_t              seg_in,
  output logic                             done,
  output logic [hcti_pkg::CAP_W-1:0]       heat_capacity
);
  import hcti_pkg::*;

  logic              valid4, valid5;
  logic [CAP_W-1:0]  lo4, lo5;
  logic [PROD_W-1:0] prod4;
  logic [P2_W-1:0]   p2_5;

  logic [PROD_W:0]   sum;
  logic [SH_W-1:0]   sh;
  logic [CAP_W-1:0]  quot;

  always_comb begin
    sum  = {1'b0, prod4} + HALF;
    sh   = sum[PROD_W:TEMP_FRAC_BITS];
    quot = p2_5[DIV2_SHIFT +: CAP_W];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid4 <= 1'b0;
      valid5 <= 1'b0;
      done   <= 1'b0;
    end else begin
      valid4 <= seg_in.valid;
      valid5 <= valid4;
      done   <= valid5;
    end
    lo4           <= seg_in.lo;
    prod4         <= seg_in.diff * seg_in.rem;
    lo5           <= lo4;
    p2_5          <= sh * DIV2_MULT;
    heat_capacity <= lo5 + quot;
  end

endmodule

`default_nettype wire

>>> rtl/heat_capacity_table_interpolator.sv
// Top level of the specific heat interpolator.
// Takes one temperature (unsigned, 1/16 K) per clock and returns the specific heat
// (1/256 J/(kg K)) interpolated from a 29-point table spanning 300 K to 3100 K; inputs
// outside that span clamp to the end entries. The block is a six-stage pipeline: a word
// issued with start reaches heat_capacity with done after the last stage, and a
// new word may be issued every cycle, so busy stays low. The receiver cannot stall the
// output; each result is present for the single cycle that done is high.
`default_nettype none

module heat_capacity_table_interpolator (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        start,
  output logic                             busy,
  input  wire logic [hcti_pkg::TEMP_W-1:0] temperature,
  output logic                             done,
  output logic [hcti_pkg::CAP_W-1:0]       heat_capacity
);
  import hcti_pkg::*;

  seg_t seg;

  assign busy = 1'b0;

  hcti_segment u_segment (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (start & ~busy),
    .temperature (temperature),
    .seg_out     (seg)
  );

  hcti_blend u_blend (
    .clk           (clk),
    .rst           (rst),
    .seg_in        (seg),
    .done          (done),
    .heat_capacity (heat_capacity)
  );

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Self-checking testbench for the specific heat table interpolator.
`default_nettype none

module tb_top;

  localparam int unsigned TW          = hcti_pkg::TEMP_W;
  localparam int unsigned CW          = hcti_pkg::CAP_W;
  localparam int unsigned FRAC_BITS   = 4;
  localparam int unsigned N_POINTS    = 29;
  localparam int unsigned TEMP_STEP   = 100 << FRAC_BITS;
  localparam int unsigned TEMP_BASE   = 300 << FRAC_BITS;
  localparam int unsigned TEMP_TOP    = TEMP_BASE + (N_POINTS - 1) * TEMP_STEP;
  localparam int          LATENCY     = 6;
  localparam int          CYCLE_LIMIT = 200000;

  // Specific heat at 300 K, 400 K, ... 3100 K in 1/256 J/(kg K)
  localparam logic [CW-1:0] CP_POINTS [N_POINTS] = '{
    18'd60291,  18'd68042,  18'd72228,  18'd74806,  18'd76572,  18'd77885,
    18'd78930,  18'd79805,  18'd80579,  18'd81303,  18'd82033,  18'd82842,
    18'd83817,  18'd85071,  18'd86725,  18'd88909,  18'd91750,  18'd95370,
    18'd99871,  18'd105334, 18'd111816, 18'd119350, 18'd127949, 18'd137600,
    18'd148268, 18'd159905, 18'd172449, 18'd185825, 18'd199956
  };

  typedef struct packed {
    logic [TW-1:0] temp;
    logic [CW-1:0] cap;
  } heat_word_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          start = 1'b0;
  logic [TW-1:0] temperature = '0;
  logic          busy;
  logic          done;
  logic [CW-1:0] heat_capacity;

  heat_word_t expected_caps[$];
  int         mismatch_count = 0;
  int         cycle_count = 0;
  bit         idle_enabled = 1'b0;

  heat_capacity_table_interpolator u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .temperature   (temperature),
    .done          (done),
    .heat_capacity (heat_capacity)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [CW-1:0] predict_heat_capacity(input logic [TW-1:0] t);
    int unsigned     off;
    int unsigned     seg;
    int unsigned     pos;
    longint unsigned lo;
    longint unsigned hi;
    longint unsigned blend;
    if (t <= TEMP_BASE) return CP_POINTS[0];
    if (t >= TEMP_TOP) return CP_POINTS[N_POINTS-1];
    off = t - TEMP_BASE;
    seg = off / TEMP_STEP;
    pos = off - seg * TEMP_STEP;
    if (seg + 1 >= N_POINTS) return CP_POINTS[N_POINTS-1];
    lo = CP_POINTS[seg];
    hi = CP_POINTS[seg+1];
    if (hi <= lo) return lo[CW-1:0];
    // round half up over one 100 K segment
    blend = lo + ((hi - lo) * pos + TEMP_STEP / 2) / TEMP_STEP;
    return blend[CW-1:0];
  endfunction

  task automatic report_mismatch(input string what, input logic [TW-1:0] t,
                                 input logic [CW-1:0] got, input logic [CW-1:0] want);
    $display("mismatch %s: temperature %0d got %0d want %0d (cycle %0d)",
             what, t, got, want, cycle_count);
    mismatch_count++;
  endtask

  // Check results first, then record the word accepted at this edge
  always @(posedge clk) begin
    heat_word_t exp_word;
    if (!rst) begin
      if (done) begin
        if (expected_caps.size() == 0) begin
          report_mismatch("unexpected result", '0, heat_capacity, '0);
        end else begin
          exp_word = expected_caps.pop_front();
          if (heat_capacity !== exp_word.cap)
            report_mismatch("heat_capacity", exp_word.temp, heat_capacity, exp_word.cap);
        end
      end
      if (start && !busy) begin
        exp_word.temp = temperature;
        exp_word.cap  = predict_heat_capacity(temperature);
        expected_caps.push_back(exp_word);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Hold start until the word is taken; start stays high for the next word
  task automatic send_temperature(input logic [TW-1:0] t);
    start       <= 1'b1;
    temperature <= t;
    do @(posedge clk); while (busy);
  endtask

  task automatic pause_start(input int n);
    start <= 1'b0;
    repeat (n) begin
      temperature <= TW'($urandom);
      @(posedge clk);
    end
  endtask

  task automatic maybe_idle();
    if (idle_enabled && $urandom_range(0, 7) == 0) pause_start($urandom_range(1, 19));
  endtask

  task automatic test_directed();
    logic [TW-1:0] temps [$];
    temps = '{16'd0, 16'd1, 16'd65535, TW'(TEMP_BASE - 1), TW'(TEMP_BASE), TW'(TEMP_BASE + 1),
              TW'(TEMP_TOP - 1), TW'(TEMP_TOP), TW'(TEMP_TOP + 1),
              TW'(TEMP_BASE + TEMP_STEP), TW'(TEMP_BASE + 2 * TEMP_STEP),
              TW'(TEMP_BASE + 27 * TEMP_STEP),
              // half way into the first and last segments: odd differences round up
              TW'(TEMP_BASE + TEMP_STEP / 2), TW'(TEMP_BASE + TEMP_STEP / 2 - 1),
              TW'(TEMP_BASE + TEMP_STEP / 2 + 1), TW'(TEMP_TOP - TEMP_STEP / 2),
              16'h8000, 16'h7FFF, 16'hAAAA, 16'h5555, 16'd27200, 16'd30001};
    foreach (temps[i]) begin
      send_temperature(temps[i]);
      maybe_idle();
    end
  endtask

  task automatic test_segment_span(input int n);
    repeat (n) begin
      if ($urandom_range(0, 4) == 0) send_temperature(TW'($urandom));
      else send_temperature(TW'($urandom_range(TEMP_BASE, TEMP_TOP)));
      maybe_idle();
    end
  endtask

  task automatic test_any_temperature(input int n);
    repeat (n) begin
      send_temperature(TW'($urandom));
      maybe_idle();
    end
  endtask

  task automatic test_back_to_back(input int n);
    repeat (n) send_temperature(TW'($urandom_range(TEMP_BASE - 40, TEMP_TOP + 40)));
  endtask

  task automatic drain_results();
    start <= 1'b0;
    while (expected_caps.size() != 0) @(posedge clk);
    // catch any stray result after the last expected one
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    idle_enabled = 1'b1;
    test_segment_span(1200);
    idle_enabled = 1'b0;
    test_segment_span(100);
    idle_enabled = 1'b1;
    test_any_temperature(200);
    idle_enabled = 1'b0;
    test_back_to_back(130);
    drain_results();
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
